@@ hdl/ahdsr_pkg.sv @@
package ahdsr_pkg;

   // defaults for the top-level parameters
   localparam int EMIT_GAP_MS_DEF = 10;
   localparam int TIME_BITS_DEF   = 20;

   // fixed-point constants
   localparam logic [15:0] FULL_SCALE = 16'hFFFF;
   localparam logic [15:0] MS_LIMIT   = 16'd60000;
   localparam logic [31:0] ROUND_HALF = 32'd32767;

   // divider widths
   localparam int DIV_W   = 32;
   localparam int DVSR_W  = 16;

   // request opcodes
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_GATE_ON  = 2'd1,
      OP_GATE_OFF = 2'd2,
      OP_CANCEL   = 2'd3
   } opcode_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_ATTACK    = 3'd0,
      REG_HOLD      = 3'd1,
      REG_DECAY     = 3'd2,
      REG_SUSTAIN   = 3'd3,
      REG_RELEASE   = 3'd4,
      REG_IN_DELAY  = 3'd5,
      REG_OUT_DELAY = 3'd6,
      REG_FLOOR     = 3'd7
   } reg_index_type;

   // divider handshake between the sequencer and the divider
   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   // clamp a written millisecond value
   function automatic logic [15:0] clamp_ms(input logic [15:0] v);
      clamp_ms = (v > MS_LIMIT) ? MS_LIMIT : v;
   endfunction

endpackage

@@ hdl/ahdsr_req_if.sv @@
interface ahdsr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] peak_level;

   modport source (output valid, output opcode, output peak_level, input ready);
   modport sink (input valid, input opcode, input peak_level, output ready);
endinterface

@@ hdl/ahdsr_rsp_if.sv @@
interface ahdsr_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] level;
   logic        finished;
   logic        last;

   modport source (output valid, output level, output finished, output last, input ready);
   modport sink (input valid, input level, input finished, input last, output ready);
endinterface

@@ hdl/delayed_ahdsr_envelope_generator_top.sv @@
// Delayed AHDSR envelope generator.
// req_if carries one request per handshake: a 1 ms tick, gate on with a
// peak level, gate off or cancel. rsp_if carries level, finished and last;
// a request causes zero, one or two responses, last marks its final one.
// csr_* is an APB-style port for the eight timing and level registers.
// Write them only while the block is idle; the block does not enforce it.
// Reads return the stored values. Gate off and idle requests leave the
// sequencer idle. A tick on a ramp runs a 16x16 multiply and a restoring
// divider, then, when an item is emitted, two multiplies and a
// shift-and-add division by full scale for the floor-to-peak mix. A tick
// on a flat phase skips the divider. The divider sets the worst case;
// req_if.ready is low until the request is done.
// A response sits in an output register; when the receiver stalls, the
// sequencer waits before writing the next one, so nothing is lost.
// Reset (synchronous, active high) stops the envelope and loads the
// register defaults (sustain at full scale, all others zero).
module delayed_ahdsr_envelope_generator_top #(
   parameter int EMIT_GAP_MS = ahdsr_pkg::EMIT_GAP_MS_DEF,
   parameter int TIME_BITS   = ahdsr_pkg::TIME_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ahdsr_req_if.sink    req_if,
   ahdsr_rsp_if.source  rsp_if,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int GAP_W = $clog2(EMIT_GAP_MS + 1);
   localparam logic [GAP_W-1:0] GAP = GAP_W'(EMIT_GAP_MS);
   localparam int CW = (TIME_BITS > 18) ? TIME_BITS : 18;

   typedef enum logic [3:0] {
      S_IDLE, S_CANCEL, S_EVAL, S_MUL_ENV, S_DIV_ENV, S_DIV_ENV_WAIT,
      S_ENV_DONE, S_MIX_A, S_MIX_B, S_MIX_C, S_MIX_WAIT, S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [15:0] attack_ff, hold_ff, decay_ff, sustain_ff;
   logic [15:0] release_ff, in_delay_ff, out_delay_ff, floor_ff;

   // envelope state
   logic                 running_ff, released_ff;
   logic [TIME_BITS-1:0] t_on_ff, t_off_ff;
   logic [15:0]          held_ff, peak_ff;
   logic [GAP_W-1:0]     since_emit_ff;

   // sequencer scratch
   logic        resume_ff, cancel_last_ff;
   logic        emit_ff, fin_ff, add_s_ff, set_held_ff;
   logic [15:0] opa_ff, opb_ff, dvsr_ff, env_ff;
   logic [31:0] prod_ff, acc_ff;

   // response register
   logic        rsp_valid_ff, rsp_fin_ff, rsp_last_ff;
   logic [15:0] rsp_level_ff;

   // divider for the envelope ramp
   ahdsr_pkg::div_ctl_type      div_ctl;
   logic [31:0]                 div_dvd;
   logic [31:0]                 div_q;

   // division of the mix sum by full scale: (x + (x >> 16) + 1) >> 16
   logic [32:0] mix_sum;

   // config port
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff    <= '0;
         hold_ff      <= '0;
         decay_ff     <= '0;
         sustain_ff   <= ahdsr_pkg::FULL_SCALE;
         release_ff   <= '0;
         in_delay_ff  <= '0;
         out_delay_ff <= '0;
         floor_ff     <= '0;
      end else if (csr_wr) begin
         case (ahdsr_pkg::reg_index_type'(csr_idx))
            ahdsr_pkg::REG_ATTACK:    attack_ff    <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_HOLD:      hold_ff      <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_DECAY:     decay_ff     <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_SUSTAIN:   sustain_ff   <= csr_pwdata[15:0];
            ahdsr_pkg::REG_RELEASE:   release_ff   <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_IN_DELAY:  in_delay_ff  <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_OUT_DELAY: out_delay_ff <= ahdsr_pkg::clamp_ms(csr_pwdata[15:0]);
            ahdsr_pkg::REG_FLOOR:     floor_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      case (ahdsr_pkg::reg_index_type'(csr_idx))
         ahdsr_pkg::REG_ATTACK:    csr_prdata[15:0] = attack_ff;
         ahdsr_pkg::REG_HOLD:      csr_prdata[15:0] = hold_ff;
         ahdsr_pkg::REG_DECAY:     csr_prdata[15:0] = decay_ff;
         ahdsr_pkg::REG_SUSTAIN:   csr_prdata[15:0] = sustain_ff;
         ahdsr_pkg::REG_RELEASE:   csr_prdata[15:0] = release_ff;
         ahdsr_pkg::REG_IN_DELAY:  csr_prdata[15:0] = in_delay_ff;
         ahdsr_pkg::REG_OUT_DELAY: csr_prdata[15:0] = out_delay_ff;
         ahdsr_pkg::REG_FLOOR:     csr_prdata[15:0] = floor_ff;
         default: ;
      endcase
   end

   // phase boundaries and compares for the evaluation step
   logic [CW-1:0] t_ext, toff_ext, ind_ext, od_ext, e1, e2, e3, u_ext;
   logic          in_delay, active;

   assign t_ext    = CW'(t_on_ff);
   assign toff_ext = CW'(t_off_ff);
   assign ind_ext  = CW'(in_delay_ff);
   assign od_ext   = CW'(out_delay_ff);
   assign e1       = ind_ext + CW'(attack_ff);
   assign e2       = e1 + CW'(hold_ff);
   assign e3       = e2 + CW'(decay_ff);
   assign u_ext    = toff_ext - od_ext;
   assign in_delay = t_ext < ind_ext;
   assign active   = !released_ff || (toff_ext < od_ext);

   // divider start and dividend for the envelope ramp
   always_comb begin
      div_ctl.start = (state_ff == S_DIV_ENV);
      div_dvd       = prod_ff;
   end

   assign mix_sum = {1'b0, acc_ff} + 33'(acc_ff[31:16]) + 33'd1;

   ahdsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (div_dvd),
      .divisor  (dvsr_ff),
      .done     (div_ctl.done),
      .quotient (div_q)
   );

   logic req_fire;
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         running_ff    <= 1'b0;
         released_ff   <= 1'b0;
         t_on_ff       <= '0;
         t_off_ff      <= '0;
         held_ff       <= '0;
         peak_ff       <= '0;
         since_emit_ff <= GAP;
         rsp_valid_ff  <= 1'b0;
         resume_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_if.ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (ahdsr_pkg::opcode_type'(req_if.opcode))
                     ahdsr_pkg::OP_TICK: begin
                        if (running_ff) begin
                           if (t_on_ff != '1)
                              t_on_ff <= t_on_ff + 1'b1;
                           if (released_ff && t_off_ff != '1)
                              t_off_ff <= t_off_ff + 1'b1;
                           if (since_emit_ff < GAP)
                              since_emit_ff <= since_emit_ff + 1'b1;
                           state_ff <= S_EVAL;
                        end
                     end
                     ahdsr_pkg::OP_GATE_ON: begin
                        cancel_last_ff <= (in_delay_ff != '0);
                        resume_ff      <= 1'b1;
                        state_ff       <= running_ff ? S_CANCEL : S_EVAL;
                        running_ff     <= 1'b1;
                        released_ff    <= 1'b0;
                        t_on_ff        <= '0;
                        t_off_ff       <= '0;
                        held_ff        <= '0;
                        peak_ff        <= req_if.peak_level;
                        since_emit_ff  <= GAP;
                     end
                     ahdsr_pkg::OP_GATE_OFF: begin
                        if (running_ff) begin
                           released_ff <= 1'b1;
                           t_off_ff    <= '0;
                        end
                     end
                     ahdsr_pkg::OP_CANCEL: begin
                        if (running_ff) begin
                           running_ff     <= 1'b0;
                           since_emit_ff  <= '0;
                           cancel_last_ff <= 1'b1;
                           resume_ff      <= 1'b0;
                           state_ff       <= S_CANCEL;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // final item of a cancelled envelope
            S_CANCEL: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= floor_ff;
                  rsp_fin_ff   <= 1'b1;
                  rsp_last_ff  <= cancel_last_ff;
                  state_ff     <= resume_ff ? S_EVAL : S_IDLE;
               end
            end
            // pick the phase and set up the ramp
            S_EVAL: begin
               fin_ff      <= 1'b0;
               add_s_ff    <= 1'b0;
               set_held_ff <= active;
               emit_ff     <= since_emit_ff >= GAP;
               if (in_delay) begin
                  state_ff <= S_IDLE;
               end else if (active) begin
                  if (t_ext < e1) begin
                     opa_ff   <= ahdsr_pkg::FULL_SCALE;
                     opb_ff   <= 16'(t_ext - ind_ext);
                     dvsr_ff  <= attack_ff;
                     state_ff <= S_MUL_ENV;
                  end else if (t_ext < e2) begin
                     env_ff   <= ahdsr_pkg::FULL_SCALE;
                     state_ff <= S_ENV_DONE;
                  end else if (t_ext < e3) begin
                     opa_ff   <= ahdsr_pkg::FULL_SCALE - sustain_ff;
                     opb_ff   <= 16'(e3 - t_ext);
                     dvsr_ff  <= decay_ff;
                     add_s_ff <= 1'b1;
                     state_ff <= S_MUL_ENV;
                  end else begin
                     env_ff   <= sustain_ff;
                     state_ff <= S_ENV_DONE;
                  end
               end else if (u_ext < CW'(release_ff)) begin
                  opa_ff   <= held_ff;
                  opb_ff   <= 16'(CW'(release_ff) - u_ext);
                  dvsr_ff  <= release_ff;
                  state_ff <= S_MUL_ENV;
               end else begin
                  env_ff     <= '0;
                  fin_ff     <= 1'b1;
                  emit_ff    <= 1'b1;
                  running_ff <= 1'b0;
                  state_ff   <= S_ENV_DONE;
               end
            end
            S_MUL_ENV: begin
               prod_ff  <= opa_ff * opb_ff;
               state_ff <= S_DIV_ENV;
            end
            S_DIV_ENV: begin
               state_ff <= S_DIV_ENV_WAIT;
            end
            S_DIV_ENV_WAIT: begin
               if (div_ctl.done) begin
                  env_ff   <= div_q[15:0] + (add_s_ff ? sustain_ff : 16'd0);
                  state_ff <= S_ENV_DONE;
               end
            end
            // latch held level and start the floor-to-peak mix
            S_ENV_DONE: begin
               if (set_held_ff)
                  held_ff <= env_ff;
               if (emit_ff) begin
                  since_emit_ff <= '0;
                  opa_ff        <= floor_ff;
                  opb_ff        <= ~env_ff;
                  state_ff      <= S_MIX_A;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_MIX_A: begin
               prod_ff  <= opa_ff * opb_ff;
               opa_ff   <= peak_ff;
               opb_ff   <= env_ff;
               state_ff <= S_MIX_B;
            end
            S_MIX_B: begin
               acc_ff   <= prod_ff;
               prod_ff  <= opa_ff * opb_ff;
               state_ff <= S_MIX_C;
            end
            // weighted sum with rounding
            S_MIX_C: begin
               acc_ff   <= acc_ff + prod_ff + ahdsr_pkg::ROUND_HALF;
               state_ff <= S_MIX_WAIT;
            end
            // divide the sum by full scale
            S_MIX_WAIT: begin
               env_ff   <= mix_sum[31:16];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_level_ff <= env_ff;
                  rsp_fin_ff   <= fin_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.level    = rsp_level_ff;
   assign rsp_if.finished = rsp_fin_ff;
   assign rsp_if.last     = rsp_last_ff;

   // a new response comes only from the two writing states
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_CANCEL || $past(state_ff) == S_OUT))
      else $error("response written outside an output state");

   // emit counter stays within its gap
   a_gap_range: assert property (@(posedge clock) disable iff (reset)
      since_emit_ff <= GAP)
      else $error("emit counter beyond gap");

   // divider finishes only while the sequencer waits for it
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> (state_ff == S_DIV_ENV_WAIT))
      else $error("divider result not expected");

   // a finishing evaluation stops the envelope
   a_fin_stops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && fin_ff) |-> !running_ff)
      else $error("envelope still running after final item");

endmodule

@@ hdl/ahdsr_div.sv @@
module ahdsr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ahdsr_pkg::DIV_W-1:0]     dividend,
   input  logic [ahdsr_pkg::DVSR_W-1:0]    divisor,
   output logic                            done,
   output logic [ahdsr_pkg::DIV_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(ahdsr_pkg::DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ahdsr_pkg::DIV_W - 1);

   logic                            busy_ff;
   logic                            done_ff;
   logic [CNT_W-1:0]                cnt_ff;
   logic [ahdsr_pkg::DIV_W-1:0]     dq_ff;
   logic [ahdsr_pkg::DVSR_W-1:0]    rem_ff;
   logic [ahdsr_pkg::DVSR_W-1:0]    dvsr_ff;
   logic [ahdsr_pkg::DVSR_W:0]      rem_sh;
   logic                            ge;

   // one restoring step per cycle
   assign rem_sh = {rem_ff, dq_ff[ahdsr_pkg::DIV_W-1]};
   assign ge     = rem_sh >= {1'b0, dvsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            dq_ff   <= dividend;
            rem_ff  <= '0;
            dvsr_ff <= divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? ahdsr_pkg::DVSR_W'(rem_sh - {1'b0, dvsr_ff})
                         : rem_sh[ahdsr_pkg::DVSR_W-1:0];
            dq_ff  <= {dq_ff[ahdsr_pkg::DIV_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule
